[src/rbpe_pkg.sv]
// ----------------------------------------------------------------------------
// rbpe_pkg
// Shared types and constants for the RGB breathing pulse engine.
// ----------------------------------------------------------------------------
package rbpe_pkg;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_DATA_W = 16;

   localparam logic [31:0] TIMEOUT_MS   = 32'd500;
   localparam logic [9:0]  DUTY_OFF     = 10'd999;
   localparam logic [15:0] SWEEP_RESET  = 16'd1000;
   localparam logic [7:0]  BRIGHT_RESET = 8'd255;
   localparam logic [7:0]  LEVEL_MAX    = 8'd255;
   // ceil(2^32 / 255); exact floor division for operands below 2^24
   localparam logic [24:0] RECIP_255    = 25'd16843010;
   localparam logic [24:0] DUTY_SCALE   = 25'd999;

   // configuration register indexes
   localparam logic CSR_SWEEP  = 1'b0;
   localparam logic CSR_BRIGHT = 1'b1;

   // multiplier passes per channel
   localparam logic [2:0] PH_COLOR  = 3'd0;
   localparam logic [2:0] PH_BRIGHT = 3'd1;
   localparam logic [2:0] PH_DIV_A  = 3'd2;
   localparam logic [2:0] PH_DIV_B  = 3'd3;
   localparam logic [2:0] PH_SCALE  = 3'd4;
   localparam logic [2:0] PH_DIV_C  = 3'd5;

   localparam logic [1:0] CH_LAST = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EVAL = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

[src/rgb_breathing_pulse_engine_unit.sv]
// ----------------------------------------------------------------------------
// rgb_breathing_pulse_engine_unit
// Triangle breathing level with per-channel active-low PWM compare values.
//
//  channel | ports          | content
//  --------+----------------+-------------------------------------------------
//  request | req_t*         | tuser: mode; tdata: now_ms, red, green, blue
//  result  | rsp_t*         | tdata: enables, duties, stepped, level_out
//  config  | csr_*          | index 0 sweep_duration_ms, index 1 brightness
//
// A beat is accepted, evaluated and output; a restart request skips the
// evaluation, and a step adds ST_MUL: one 24x25 multiplier makes six passes
// per channel. req_tready is high only while idle. Reset is synchronous.
// A stalled result holds in the output register; one more beat is taken and
// then waits in ST_DONE until the register frees up.
// ----------------------------------------------------------------------------
module rgb_breathing_pulse_engine_unit
   import rbpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] now_ms, [39:32] red, [47:40] green, [55:48] blue
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] mode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] red_on, [1] green_on, [2] blue_on, [12:3] red_duty,
   // [22:13] green_duty, [32:23] blue_duty, [33] stepped, [41:34] level_out
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   state_type         state_ff, state_in;
   logic [15:0]       sweep_ff, sweep_in;
   logic [7:0]        bright_ff, bright_in;
   logic [7:0]        level_ff, level_in;
   logic              rising_ff, rising_in;
   logic [31:0]       last_step_ff, last_step_in;
   logic [31:0]       last_call_ff, last_call_in;
   logic              armed_ff, armed_in;
   logic [2:0][7:0]   prev_ff, prev_in;
   logic              pending_ff, pending_in;
   logic [2:0][9:0]   duty_ff, duty_in;
   logic [2:0]        enables_ff, enables_in;
   logic              stepped_ff, stepped_in;
   logic [31:0]       now_ff, now_in;
   logic [2:0][7:0]   col_ff, col_in;
   logic [1:0]        ch_ff, ch_in;
   logic [2:0]        ph_ff, ph_in;
   logic [23:0]       acc_ff, acc_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic              req_take;
   logic              restart;
   logic [31:0]       step_base;
   logic [7:0]        level_base;
   logic              rising_base;
   logic              armed_base;
   logic [2:0][7:0]   prev_base;
   logic              rearm;
   logic [6:0]        delay;
   logic              due;
   logic [23:0]       mul_a;
   logic [24:0]       mul_b;
   logic [48:0]       prod;
   logic              out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // call evaluation
   assign restart     = pending_ff || ((now_ff - last_call_ff) > TIMEOUT_MS);
   assign step_base   = restart ? now_ff : last_step_ff;
   assign level_base  = restart ? 8'd0 : level_ff;
   assign rising_base = restart ? 1'b1 : rising_ff;
   assign armed_base  = restart ? 1'b0 : armed_ff;
   assign prev_base   = restart ? '0 : prev_ff;
   assign rearm       = !armed_base || (prev_base != col_ff);
   assign delay       = (sweep_ff[15:9] == 7'd0) ? 7'd1 : sweep_ff[15:9];
   assign due         = (now_ff - step_base) >= {25'd0, delay};

   // shared multiplier
   always_comb begin
      case (ph_ff)
         PH_COLOR:  begin
            mul_a = {16'd0, col_ff[ch_ff]};
            mul_b = {17'd0, level_ff};
         end
         PH_BRIGHT: begin
            mul_a = acc_ff;
            mul_b = {17'd0, bright_ff};
         end
         PH_SCALE:  begin
            mul_a = acc_ff;
            mul_b = DUTY_SCALE;
         end
         default:   begin
            mul_a = acc_ff;
            mul_b = RECIP_255;
         end
      endcase
   end
   assign prod = {25'd0, mul_a} * {24'd0, mul_b};

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      bright_in     = bright_ff;
      level_in      = level_ff;
      rising_in     = rising_ff;
      last_step_in  = last_step_ff;
      last_call_in  = last_call_ff;
      armed_in      = armed_ff;
      prev_in       = prev_ff;
      pending_in    = pending_ff;
      duty_in       = duty_ff;
      enables_in    = enables_ff;
      stepped_in    = stepped_ff;
      now_in        = now_ff;
      col_in        = col_ff;
      ch_in         = ch_ff;
      ph_in         = ph_ff;
      acc_in        = acc_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SWEEP:  sweep_in  = csr_data;
            CSR_BRIGHT: bright_in = csr_data[7:0];
            default:    ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               now_in     = req_tdata[31:0];
               col_in[0]  = req_tdata[39:32];
               col_in[1]  = req_tdata[47:40];
               col_in[2]  = req_tdata[55:48];
               stepped_in = 1'b0;
               if (req_tuser) begin
                  pending_in = 1'b1;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            pending_in   = 1'b0;
            last_call_in = now_ff;
            level_in     = level_base;
            rising_in    = rising_base;
            last_step_in = step_base;
            armed_in     = 1'b1;
            prev_in      = col_ff;
            if (rearm) begin
               for (int i = 0; i < 3; i++) begin
                  enables_in[i] = (col_ff[i] != 8'd0);
                  if (col_ff[i] == 8'd0) begin
                     duty_in[i] = DUTY_OFF;
                  end
               end
            end
            if (due) begin
               last_step_in = now_ff;
               stepped_in   = 1'b1;
               if (rising_base) begin
                  level_in = level_base + 8'd1;
                  if (level_in == LEVEL_MAX) begin
                     rising_in = 1'b0;
                  end
               end else begin
                  if (level_base != 8'd0) begin
                     level_in = level_base - 8'd1;
                  end
                  if (level_in == 8'd0) begin
                     rising_in = 1'b1;
                  end
               end
               ch_in    = 2'd0;
               ph_in    = PH_COLOR;
               state_in = ST_MUL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            if (ph_ff == PH_DIV_A || ph_ff == PH_DIV_B || ph_ff == PH_DIV_C) begin
               acc_in = {7'd0, prod[48:32]};
            end else begin
               acc_in = prod[23:0];
            end
            if (ph_ff == PH_DIV_C) begin
               if (col_ff[ch_ff] != 8'd0) begin
                  duty_in[ch_ff] = DUTY_OFF - prod[41:32];
               end
               ph_in = PH_COLOR;
               if (ch_ff == CH_LAST) begin
                  state_in = ST_DONE;
               end else begin
                  ch_in = ch_ff + 2'd1;
               end
            end else begin
               ph_in = ph_ff + 3'd1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {6'd0, level_ff, stepped_ff, duty_ff[2], duty_ff[1],
                                duty_ff[0], enables_ff};
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sweep_ff      <= SWEEP_RESET;
         bright_ff     <= BRIGHT_RESET;
         level_ff      <= 8'd0;
         rising_ff     <= 1'b1;
         last_step_ff  <= 32'd0;
         last_call_ff  <= 32'd0;
         armed_ff      <= 1'b0;
         prev_ff       <= '0;
         pending_ff    <= 1'b0;
         duty_ff       <= {DUTY_OFF, DUTY_OFF, DUTY_OFF};
         enables_ff    <= 3'd0;
         ch_ff         <= 2'd0;
         ph_ff         <= PH_COLOR;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         bright_ff     <= bright_in;
         level_ff      <= level_in;
         rising_ff     <= rising_in;
         last_step_ff  <= last_step_in;
         last_call_ff  <= last_call_in;
         armed_ff      <= armed_in;
         prev_ff       <= prev_in;
         pending_ff    <= pending_in;
         duty_ff       <= duty_in;
         enables_ff    <= enables_in;
         ch_ff         <= ch_in;
         ph_ff         <= ph_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      stepped_ff   <= stepped_in;
      now_ff       <= now_in;
      col_ff       <= col_in;
      acc_ff       <= acc_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_tready)
      else $error("ready while a beat is in flight");

   a_peak_falls: assert property (@(posedge clock) disable iff (reset)
      (level_ff == LEVEL_MAX) |-> !rising_ff)
      else $error("rising at full level");

   a_falling_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rising_ff |-> (level_ff != 8'd0))
      else $error("falling at dark level");

   a_seq_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (ph_ff <= PH_DIV_C && ch_ff <= CH_LAST))
      else $error("sequencer out of range");

endmodule
